FILE: rtl/exchange_sort_ascending_top_macros.svh
// assertion macros shared by the exchange sort checker
`ifndef EXCHANGE_SORT_ASCENDING_TOP_MACROS_SVH
`define EXCHANGE_SORT_ASCENDING_TOP_MACROS_SVH

// implication checked on every rising edge outside reset
`define ESA_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("exchange sort check failed");

// condition that must never hold outside reset
`define ESA_ASSERT_NEVER(lbl, ck, rn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rn) !(cond)) \
    else $error("exchange sort check failed");

`endif

FILE: rtl/esa_pkg.sv
// types and state codes shared by the exchange sort modules
`timescale 1ns / 1ps

package esa_pkg;

  localparam int WORD_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;

  // sequencer states, one-hot
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_RD_I   = 8'b0000_0010,
    S_LD_I   = 8'b0000_0100,
    S_CMP    = 8'b0000_1000,
    S_WR_I   = 8'b0001_0000,
    S_OUT_RD = 8'b0010_0000,
    S_OUT_LD = 8'b0100_0000,
    S_OUT    = 8'b1000_0000
  } state_t;

  // result of one compare-exchange
  typedef struct packed {
    logic  swap;
    word_t keep;
    word_t spill;
  } cmp_res_t;

endpackage

FILE: rtl/exchange_sort_ascending_top.sv
// exchange sort top level: element store, sequencer and output register
`timescale 1ns / 1ps
// after the closing transaction the set is sorted in place, with no sorting for a single element;
// then each result goes through memory read, load and hand-off, and waits while out_tready is low
// throughput: one element transaction per cycle while loading; one compare-exchange per cycle
// within a pass while sorting; the element store has a single write port
// reset: rst_n synchronous active low, clears sequencer, count and overflow flag; store unset

module exchange_sort_ascending_top #(
  parameter int MAX_ELEMS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // element channel
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [31:0]           in_tdata,   // [31:0] value
  input  logic                  in_tlast,   // is_final
  // sorted channel
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [31:0]           out_tdata,  // [31:0] sorted_value
  output logic                  out_tlast,  // end_of_run
  output logic                  out_tuser   // [0] overflowed
);
  import esa_pkg::*;

  localparam int AW = $clog2(MAX_ELEMS);      // store address width
  localparam int CW = $clog2(MAX_ELEMS + 1);  // element count width

  // element store, registered read
  word_t            mem [MAX_ELEMS];
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  word_t            mem_wdata;
  logic [AW-1:0]    rd_addr;
  word_t            rd_data_r;

  state_t           state_r, state_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             ovf_r, ovf_nxt;
  logic [AW-1:0]    i_r, i_nxt;       // outer position
  logic [AW-1:0]    j_r, j_nxt;       // inner position
  logic [AW-1:0]    k_r, k_nxt;       // output position
  word_t            cur_r, cur_nxt;   // value held for position i
  word_t            out_data_r, out_data_nxt;
  logic             out_last_r, out_last_nxt;
  logic             in_acc;
  cmp_res_t         cmp;

  esa_cmp_unit u_cmp (
    .held  (cur_r),
    .probe (rd_data_r),
    .res   (cmp)
  );

  assign in_acc = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  always_comb begin
    state_nxt    = state_r;
    count_nxt    = count_r;
    ovf_nxt      = ovf_r;
    i_nxt        = i_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    cur_nxt      = cur_r;
    out_data_nxt = out_data_r;
    out_last_nxt = out_last_r;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = in_tdata;
    rd_addr      = '0;
    in_tready    = 1'b0;
    out_tvalid   = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_acc) begin
          // store if there is room, otherwise drop and flag
          if (count_r < CW'(MAX_ELEMS)) begin
            mem_we    = 1'b1;
            mem_waddr = count_r[AW-1:0];
            count_nxt = count_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_tlast) begin
            i_nxt = '0;
            k_nxt = '0;
            // a single element needs no sorting
            state_nxt = (count_nxt == CW'(1)) ? S_OUT_RD : S_RD_I;
          end
        end
      end
      S_RD_I: begin
        rd_addr   = i_r;
        j_nxt     = i_r + AW'(1);
        state_nxt = S_LD_I;
      end
      S_LD_I: begin
        cur_nxt   = rd_data_r;
        rd_addr   = j_r;
        state_nxt = S_CMP;
      end
      S_CMP: begin
        // larger value goes back to position j, smaller one stays held
        mem_we    = cmp.swap;
        mem_waddr = j_r;
        mem_wdata = cmp.spill;
        cur_nxt   = cmp.keep;
        if (CW'(j_r) + CW'(1) < count_r) begin
          j_nxt   = j_r + AW'(1);
          rd_addr = j_r + AW'(1);
        end else begin
          state_nxt = S_WR_I;
        end
      end
      S_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = cur_r;
        if (CW'(i_r) + CW'(2) < count_r) begin
          i_nxt     = i_r + AW'(1);
          state_nxt = S_RD_I;
        end else begin
          k_nxt     = '0;
          state_nxt = S_OUT_RD;
        end
      end
      S_OUT_RD: begin
        rd_addr   = k_r;
        state_nxt = S_OUT_LD;
      end
      S_OUT_LD: begin
        out_data_nxt = rd_data_r;
        out_last_nxt = (CW'(k_r) + CW'(1) == count_r);
        state_nxt    = S_OUT;
      end
      S_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (out_last_r) begin
            // run done, open a fresh set
            count_nxt = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_IDLE;
          end else begin
            k_nxt     = k_r + AW'(1);
            state_nxt = S_OUT_RD;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      i_r        <= '0;
      j_r        <= '0;
      k_r        <= '0;
      out_last_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      i_r        <= i_nxt;
      j_r        <= j_nxt;
      k_r        <= k_nxt;
      out_last_r <= out_last_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tdata = out_data_r;
  assign out_tlast = out_last_r;
  assign out_tuser = ovf_r;

endmodule

FILE: rtl/esa_cmp_unit.sv
// compare-exchange unit: smaller value kept, larger value spilled
`timescale 1ns / 1ps

module esa_cmp_unit (
  input  esa_pkg::word_t    held,
  input  esa_pkg::word_t    probe,
  output esa_pkg::cmp_res_t res
);
  import esa_pkg::*;

  logic greater;

  // signed compare, equal values stay put
  assign greater   = held > probe;
  assign res.swap  = greater;
  assign res.keep  = greater ? probe : held;
  assign res.spill = greater ? held  : probe;

endmodule

FILE: rtl/esa_checker.sv
// port-level checker for the exchange sort top level, with its bind
`timescale 1ns / 1ps
`include "exchange_sort_ascending_top_macros.svh"

module esa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tlast,
  input logic        out_tuser
);

  logic in_acc;
  logic out_acc;

  assign in_acc  = in_tvalid && in_tready;
  assign out_acc = out_tvalid && out_tready;

  // never taking elements while a result is on offer
  `ESA_ASSERT_NEVER(a_no_overlap, clk, rst_n, in_tready && out_tvalid)
  // closing transaction starts the sort, input closes
  `ESA_ASSERT_IMPL(a_close_stalls, clk, rst_n, in_acc && in_tlast, !in_tready)
  // end of run reopens the input
  `ESA_ASSERT_IMPL(a_run_reopens, clk, rst_n, out_acc && out_tlast, in_tready && !out_tvalid)
  // stalled result holds
  `ESA_ASSERT_IMPL(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tlast) && $stable(out_tuser))

endmodule

bind exchange_sort_ascending_top esa_checker u_esa_checker (.*);

FILE: sim/exchange_sort_ascending_top_tb.sv
// self-checking bench for the exchange sort: directed and random element sets against a predictor
`timescale 1ns / 1ps

module exchange_sort_ascending_top_tb;
  import esa_pkg::word_t;

  localparam int ELEM_CAP     = 64;      // store depth of the instance under test
  localparam int RANDOM_ITEMS = 20;      // element transactions in small random sets
  localparam int HOLD_AFTER   = 12;      // results accepted before the long output hold-off
  localparam int HOLD_CYCLES  = 600;     // length of that hold-off
  localparam int TAIL_CYCLES  = 200;     // quiet time after the last result
  localparam int CYCLE_LIMIT  = 300000;  // watchdog, many times the slowest correct run

  // one pending element transaction
  typedef struct {
    word_t value;
    logic  is_final;
    bit    drain_first;  // hold this one back until every sorted result has arrived
  } elem_item_t;

  // one sorted result as it should appear on the output channel
  typedef struct packed {
    word_t sorted_value;
    logic  end_of_run;
    logic  overflowed;
  } sorted_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // [31:0] value
  logic        in_tlast = 1'b0; // is_final
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [31:0] sorted_value
  logic        out_tlast;       // end_of_run
  logic        out_tuser;       // [0] overflowed

  elem_item_t     pending_elems[$];
  sorted_result_t sorted_due[$];

  // predictor copy of the block state
  word_t held_elems[$];
  bit    held_overflow = 1'b0;

  int elems_queued = 0;
  int elems_accepted = 0;
  int results_seen = 0;
  int error_count = 0;
  int cycle_count = 0;

  // idling: each side switches between bursty and gap-free stretches
  bit send_bursty = 1'b0;
  bit recv_bursty = 1'b1;
  int send_gap = 0;
  int recv_stall = 0;
  int long_hold_left = 0;
  bit long_hold_done = 1'b0;

  exchange_sort_ascending_top #(
    .MAX_ELEMS(ELEM_CAP)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #4 clk = ~clk;

  // wait cycles for the next transaction on one side
  function automatic int draw_gap(bit bursty);
    return bursty ? int'($urandom_range(0, 17)) : 0;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at cycle %0d: %s", cycle_count, msg);
    error_count++;
  endtask

  // absorb one accepted element; a closing element sorts the set and queues its results
  task automatic absorb_element(input word_t value, input logic is_final);
    word_t          ordered[$];
    word_t          tmp;
    int             n;
    sorted_result_t due;
    if (held_elems.size() < ELEM_CAP) begin
      held_elems.insert(held_elems.size(), value);
    end else begin
      held_overflow = 1'b1;  // no room: element dropped, closing one included
    end
    if (is_final) begin
      ordered = held_elems;
      n = ordered.size();
      // exchange sort: earlier slot swaps with any later smaller one, equals stay put
      for (int i = 0; i < n; i++) begin
        for (int j = i + 1; j < n; j++) begin
          if (ordered[i] > ordered[j]) begin
            tmp = ordered[i];
            ordered[i] = ordered[j];
            ordered[j] = tmp;
          end
        end
      end
      for (int k = 0; k < n; k++) begin
        due = '{ordered[k], logic'(k == n - 1), held_overflow};
        sorted_due.insert(sorted_due.size(), due);
      end
      held_elems.delete();
      held_overflow = 1'b0;
    end
  endtask

  task automatic queue_element(input word_t value, input logic is_final, input bit drain);
    elem_item_t entry;
    entry = '{value, is_final, drain};
    pending_elems.insert(pending_elems.size(), entry);
    elems_queued++;
  endtask

  // element values: full range, a narrow band full of duplicates, or the corners
  function automatic word_t pick_value(int flavour);
    case (flavour)
      0: return word_t'($urandom);
      1: return word_t'(int'($urandom_range(0, 15)) - 8);
      default: begin
        case ($urandom_range(0, 6))
          0: return 32'sh8000_0000;
          1: return 32'sh8000_0001;
          2: return 32'sh7fff_ffff;
          3: return 32'sh7fff_fffe;
          4: return -32'sd1;
          5: return 32'sd0;
          default: return 32'sd1;
        endcase
      end
    endcase
  endfunction

  task automatic queue_set(input int set_size, input int flavour, input bit drain);
    for (int k = 0; k < set_size; k++) begin
      queue_element(pick_value(flavour), logic'(k == set_size - 1), drain && k == 0);
    end
  endtask

  // sender: presents pending elements, predicts on each accepted transaction
  always @(posedge clk) begin : element_driver
    elem_item_t next_item;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= '0;
      in_tlast  <= 1'b0;
      send_gap  <= 0;
    end else begin
      if (in_tvalid && in_tready) begin
        absorb_element(word_t'(in_tdata), in_tlast);
        elems_accepted++;
      end
      // the channel is free when nothing is offered or the offer was just taken
      if (!in_tvalid || in_tready) begin
        if (send_gap != 0) begin
          in_tvalid <= 1'b0;
          send_gap  <= send_gap - 1;
        end else if (pending_elems.size() != 0 &&
                     !(pending_elems[0].drain_first && sorted_due.size() != 0)) begin
          next_item = pending_elems.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= next_item.value;
          in_tlast  <= next_item.is_final;
          if ($urandom_range(0, 15) == 0) send_bursty = ~send_bursty;
          send_gap  <= draw_gap(send_bursty);
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // receiver: checks each accepted result against the oldest prediction, paces out_tready
  always @(posedge clk) begin : sorted_monitor
    sorted_result_t want;
    int stall;
    if (!rst_n) begin
      out_tready     <= 1'b0;
      recv_stall     <= 0;
      long_hold_left <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (sorted_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d", $signed(out_tdata)));
        end else begin
          want = sorted_due.pop_front();
          if (out_tdata !== want.sorted_value)
            report_mismatch($sformatf("result %0d sorted_value got %0d want %0d",
                                      results_seen, $signed(out_tdata), want.sorted_value));
          if (out_tlast !== want.end_of_run)
            report_mismatch($sformatf("result %0d end_of_run got %b want %b",
                                      results_seen, out_tlast, want.end_of_run));
          if (out_tuser !== want.overflowed)
            report_mismatch($sformatf("result %0d overflowed got %b want %b",
                                      results_seen, out_tuser, want.overflowed));
        end
        results_seen++;
      end
      // one long hold-off so the block backs up and stalls its input
      if (results_seen == HOLD_AFTER && !long_hold_done) begin
        long_hold_done <= 1'b1;
        long_hold_left <= HOLD_CYCLES;
        out_tready     <= 1'b0;
      end else if (long_hold_left != 0) begin
        long_hold_left <= long_hold_left - 1;
        out_tready     <= 1'b0;
      end else if (out_tvalid && out_tready) begin
        if ($urandom_range(0, 15) == 0) recv_bursty = ~recv_bursty;
        stall = draw_gap(recv_bursty);
        out_tready <= (stall == 0);
        recv_stall <= (stall == 0) ? 0 : stall - 1;
      end else if (recv_stall != 0) begin
        recv_stall <= recv_stall - 1;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[exchange_sort_ascending_top] ERROR");
      $finish;
    end
  end

  initial begin : stimulus
    int  set_size;
    int  random_items;
    random_items = 0;

    // directed: single element at the minimum
    queue_element(32'sh8000_0000, 1'b1, 1'b0);
    // two extremes in reverse order
    queue_element(32'sh7fff_ffff, 1'b0, 1'b0);
    queue_element(32'sh8000_0000, 1'b1, 1'b0);
    // around zero
    queue_element(32'sd0, 1'b0, 1'b0);
    queue_element(-32'sd1, 1'b0, 1'b0);
    queue_element(32'sd1, 1'b1, 1'b0);
    // equal values must not disturb the order
    queue_element(32'sd7, 1'b0, 1'b0);
    queue_element(-32'sd7, 1'b0, 1'b0);
    queue_element(32'sd7, 1'b0, 1'b0);
    queue_element(32'sd7, 1'b1, 1'b0);
    // descending across the whole range, maximum repeated
    queue_element(32'sh7fff_ffff, 1'b0, 1'b0);
    queue_element(32'sh7fff_ffff, 1'b0, 1'b0);
    queue_element(32'sh7fff_fffe, 1'b0, 1'b0);
    queue_element(32'sd1, 1'b0, 1'b0);
    queue_element(32'sd0, 1'b0, 1'b0);
    queue_element(-32'sd1, 1'b0, 1'b0);
    queue_element(32'sh8000_0001, 1'b0, 1'b0);
    queue_element(32'sh8000_0000, 1'b1, 1'b0);
    // already ascending
    queue_element(32'sh8000_0000, 1'b0, 1'b0);
    queue_element(-32'sd1, 1'b0, 1'b0);
    queue_element(32'sd0, 1'b0, 1'b0);
    queue_element(32'sh7fff_ffff, 1'b1, 1'b0);

    // random sets, mostly small; sender drains before the first set and before some later ones
    while (random_items < RANDOM_ITEMS) begin
      set_size = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
      queue_set(set_size, $urandom_range(0, 2), random_items == 0 || $urandom_range(0, 7) == 0);
      random_items += set_size;
    end
    // overflow: store filled, then non-closing and closing elements dropped, after a full drain
    queue_set(ELEM_CAP + 3, 0, 1'b1);
    // following set must start clean, overflow flag cleared
    queue_set($urandom_range(1, 5), 2, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    while (elems_accepted != elems_queued) @(posedge clk);
    while (sorted_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("[exchange_sort_ascending_top] OK");
    end else begin
      $display("[exchange_sort_ascending_top] ERROR");
    end
    $finish;
  end

endmodule
